/* design/dfq_pkg.sv */
// Shared constants, types and result codes for the duplicate-rejecting queue.
package dfq_pkg;

  localparam int DEPTH   = 16;
  localparam int VAL_W   = 32;
  localparam int OCC_W   = 5;
  localparam int CNT_W   = (DEPTH > 1) ? $clog2(DEPTH + 1) : 1;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [1:0]              status_t;
  typedef logic [OCC_W-1:0]        occ_t;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_DUP   = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_EMPTY = 2'd3;

  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);

  // control broadcast from the sequencer to every cell of the row
  typedef struct packed {
    value_t key;    // word under test, and the word to load on insert
    cnt_t   count;  // items held; cells below this index are live
    logic   shift;  // move every word one cell towards the head
    logic   load;   // write key into the cell whose index equals count
  } dfq_cell_ctrl_t;

endpackage

/* design/dfq_ifs.sv */
// Handshake channel interfaces for the queue's operation and result words.
interface dfq_in_if import dfq_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   action;
  value_t item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

interface dfq_out_if import dfq_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  occ_t    occupancy;
  value_t  removed_value;

  modport source (output valid, output status, output occupancy, output removed_value,
                  input ready);
  modport sink   (input valid, input status, input occupancy, input removed_value,
                  output ready);
endinterface

/* design/dedup_fifo_queue.sv */
// Top level: first-in first-out queue of signed words that rejects duplicates.
// An operation is taken in S_IDLE, compared in S_CMP and committed in S_COMMIT,
//   which waits until the output register is free. The compare-then-commit pass over
//   the cell row handles one operation at a time; no new one is taken until commit.
// A pending result waits in the output register while the next operation is taken.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
module dedup_fifo_queue import dfq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dfq_in_if.sink     in_ch,
  dfq_out_if.source  out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COMMIT
  } state_t;

  state_t  state_r;
  cnt_t    count_r;
  value_t  key_r;
  logic    action_r;
  logic    out_valid_r;
  status_t out_status_r;
  occ_t    out_occ_r;
  value_t  out_removed_r;

  // row of cells; the head word lives in cell 0
  value_t         cell_value [DEPTH];
  logic   [DEPTH-1:0] cell_match;
  dfq_cell_ctrl_t ctrl;

  logic    out_free;
  logic    commit;
  logic    any_match;
  status_t status_nxt;
  cnt_t    count_nxt;
  value_t  removed_nxt;
  logic    do_load;
  logic    do_shift;

  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = (state_r == S_COMMIT) && out_free;
  assign any_match = |cell_match;

  // decide the outcome from the registered compare results
  always_comb begin
    status_nxt  = ST_OK;
    count_nxt   = count_r;
    removed_nxt = '0;
    do_load     = 1'b0;
    do_shift    = 1'b0;
    if (action_r == ACT_INSERT) begin
      if (any_match) begin
        status_nxt = ST_DUP;
      end else if (count_r >= DEPTH_CNT) begin
        status_nxt = ST_FULL;
      end else begin
        do_load   = 1'b1;
        count_nxt = count_r + cnt_t'(1);
      end
    end else begin
      if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        do_shift    = 1'b1;
        removed_nxt = cell_value[0];
        count_nxt   = count_r - cnt_t'(1);
      end
    end
  end

  // broadcast to the row; writes only fire on the commit cycle
  always_comb begin
    ctrl.key   = key_r;
    ctrl.count = count_r;
    ctrl.shift = commit && do_shift;
    ctrl.load  = commit && do_load;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t neighbour;
    if (i == DEPTH - 1) begin : g_tail
      assign neighbour = cell_value[i];
    end else begin : g_mid
      assign neighbour = cell_value[i+1];
    end
    dfq_cell u_cell (
      .clk        (clk),
      .cell_index (cnt_t'(i)),
      .ctrl       (ctrl),
      .next_value (neighbour),
      .value      (cell_value[i]),
      .match      (cell_match[i])
    );
  end

  // sequencer: take one operation, let the cells compare, then commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a fresh one replaces it this cycle
      if (out_valid_r && out_ch.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            key_r    <= in_ch.item_value;
            action_r <= in_ch.action;
            state_r  <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          // hold until the output register is free
          if (out_free) begin
            count_r       <= count_nxt;
            out_valid_r   <= 1'b1;
            out_status_r  <= status_nxt;
            out_occ_r     <= occ_t'(count_nxt);
            out_removed_r <= removed_nxt;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.occupancy     = out_occ_r;
  assign out_ch.removed_value = out_removed_r;

endmodule

/* design/dfq_cell.sv */
// One storage cell of the queue row: holds a word, compares it, shifts it headwards.
module dfq_cell import dfq_pkg::*; (
  input  logic           clk,
  input  cnt_t           cell_index,
  input  dfq_cell_ctrl_t ctrl,
  input  value_t         next_value,
  output value_t         value,
  output logic           match
);

  value_t value_r, value_nxt;
  logic   match_r, match_nxt;
  logic   live;

  assign live = (cell_index < ctrl.count);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.shift) begin
      value_nxt = next_value;
    end else if (ctrl.load && (cell_index == ctrl.count)) begin
      value_nxt = ctrl.key;
    end
    match_nxt = live && (value_r == ctrl.key);
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    match_r <= match_nxt;
  end

  assign value = value_r;
  assign match = match_r;

endmodule
